// File: sv/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types, constants and arithmetic helpers of the fire palette pixel
// render pipeline.
// ----------------------------------------------------------------------------
package fpr_pkg;

  // configuration register indexes
  localparam int unsigned CfgIndexWidth = 2;
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_BRIGHTNESS    = 2'd0,
    REG_FLARE_LEVEL   = 2'd1,
    REG_STACK_REVERSE = 2'd2,
    REG_ROW_INVERT    = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] BrightnessReset = 8'd245;
  localparam logic [7:0] BrightnessCap   = 8'd245;

  // palette band edges
  localparam logic [7:0] BandMid  = 8'd64;
  localparam logic [7:0] BandHigh = 8'd160;

  // flare rows and shaping
  localparam logic [5:0] FlareRowLow  = 6'd11;
  localparam logic [5:0] FlareRowHigh = 6'd37;
  localparam logic [5:0] FlareRowMid  = 6'd24;
  localparam logic [5:0] FlareRowSpan = 6'd48;

  // stage 1 result: base palette color, row flare level, canvas position
  typedef struct packed {
    logic [8:0] rr;
    logic [8:0] gg;
    logic [3:0] bb;
    logic [7:0] fk;
    logic [7:0] bri;
    logic [5:0] cx;
    logic [3:0] cy;
  } front_t;

  // stage 2 result: flare products before the divide by 255
  typedef struct packed {
    logic [8:0]  rr;
    logic [8:0]  gg;
    logic [3:0]  bb;
    logic [11:0] f10;
    logic [13:0] f40;
    logic [13:0] f60;
    logic [7:0]  bri;
    logic [5:0]  cx;
    logic [3:0]  cy;
  } flare_t;

  // stage 3 result: clamped channels
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] bri;
    logic [5:0] cx;
    logic [3:0] cy;
  } blend_t;

  // stage 4 result: scaled channels with rounding bias, before the divide
  typedef struct packed {
    logic [15:0] pr;
    logic [15:0] pg;
    logic [15:0] pb;
    logic [5:0]  cx;
    logic [3:0]  cy;
  } scale_t;

  // floor(x / 255) for x below 65280: y = x + 1, q = (y + y/256) / 256
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] y;
    logic [16:0] s;
    y = {1'b0, x} + 17'd1;
    s = y + {8'd0, y[16:8]};
    return s[15:8];
  endfunction

endpackage

// File: sv/fpr_front.sv
// ----------------------------------------------------------------------------
// fpr_front
// Three-band fire palette, per-row flare level, brightness cap and canvas
// position of one heat cell.
// ----------------------------------------------------------------------------
module fpr_front (
  input  logic [7:0]     heat_value,
  input  logic [3:0]     column,
  input  logic [5:0]     row,
  input  logic [7:0]     brightness,
  input  logic [7:0]     flare_level,
  input  logic           stack_reverse,
  input  logic           row_invert,
  output fpr_pkg::front_t front
);
  import fpr_pkg::*;

  logic [7:0]  t;
  logic [15:0] t43;
  logic [5:0]  m;
  logic [8:0]  fsum;
  logic [1:0]  seg;

  always_comb begin
    front = '0;
    t     = '0;
    t43   = '0;
    if (heat_value < BandMid) begin
      front.rr = {1'b0, heat_value} * 9'd3;
      front.gg = {2'b0, heat_value[7:1]};
      front.bb = '0;
    end else if (heat_value < BandHigh) begin
      t        = heat_value - BandMid;
      front.rr = 9'd192 + {1'b0, t};
      front.gg = 9'd16 + {t, 1'b0};
      front.bb = '0;
    end else begin
      t        = heat_value - BandHigh;
      // t / 6 for t up to 95
      t43      = {8'd0, t} * 16'd43;
      front.rr = 9'd255;
      front.gg = 9'd200 + {1'b0, t};
      front.bb = t43[11:8];
    end

    m    = (row < FlareRowMid) ? row : (FlareRowSpan - row);
    fsum = {1'b0, flare_level} + ({3'd0, m} * 9'd6);
    if (flare_level != '0 && row >= FlareRowLow && row <= FlareRowHigh) begin
      front.fk = fsum[8] ? 8'd255 : fsum[7:0];
    end else begin
      front.fk = '0;
    end

    front.bri = (brightness > BrightnessCap) ? BrightnessCap : brightness;

    seg = row[5:4];
    if (stack_reverse) begin
      seg = 2'd2 - seg;
    end
    front.cx = {seg, column};
    front.cy = row[3:0] ^ {4{row_invert}};
  end

endmodule

// File: sv/fpr_flare.sv
// ----------------------------------------------------------------------------
// fpr_flare
// Flare whitening products: row flare level times the per-channel weight.
// ----------------------------------------------------------------------------
module fpr_flare (
  input  fpr_pkg::front_t front,
  output fpr_pkg::flare_t flare
);
  import fpr_pkg::*;

  always_comb begin
    flare.rr  = front.rr;
    flare.gg  = front.gg;
    flare.bb  = front.bb;
    flare.f10 = {4'd0, front.fk} * 12'd10;
    flare.f40 = {6'd0, front.fk} * 14'd40;
    flare.f60 = {6'd0, front.fk} * 14'd60;
    flare.bri = front.bri;
    flare.cx  = front.cx;
    flare.cy  = front.cy;
  end

endmodule

// File: sv/fpr_blend.sv
// ----------------------------------------------------------------------------
// fpr_blend
// Adds the flare whitening to the palette color and clamps each channel.
// ----------------------------------------------------------------------------
module fpr_blend (
  input  fpr_pkg::flare_t flare,
  output fpr_pkg::blend_t blend
);
  import fpr_pkg::*;

  logic [9:0] rs;
  logic [9:0] gs;
  logic [9:0] bs;

  always_comb begin
    rs = {1'b0, flare.rr} + {2'd0, div255({4'd0, flare.f10})};
    gs = {1'b0, flare.gg} + {2'd0, div255({2'd0, flare.f40})};
    bs = {6'd0, flare.bb} + {2'd0, div255({2'd0, flare.f60})};
    blend.r   = (rs > 10'd255) ? 8'd255 : rs[7:0];
    blend.g   = (gs > 10'd255) ? 8'd255 : gs[7:0];
    blend.b   = (bs > 10'd255) ? 8'd255 : bs[7:0];
    blend.bri = flare.bri;
    blend.cx  = flare.cx;
    blend.cy  = flare.cy;
  end

endmodule

// File: sv/fpr_scale.sv
// ----------------------------------------------------------------------------
// fpr_scale
// Brightness multiply of each channel with the rounding bias added.
// ----------------------------------------------------------------------------
module fpr_scale (
  input  fpr_pkg::blend_t blend,
  output fpr_pkg::scale_t scale
);
  import fpr_pkg::*;

  always_comb begin
    scale.pr = ({8'd0, blend.r} * {8'd0, blend.bri}) + 16'd127;
    scale.pg = ({8'd0, blend.g} * {8'd0, blend.bri}) + 16'd127;
    scale.pb = ({8'd0, blend.b} * {8'd0, blend.bri}) + 16'd127;
    scale.cx = blend.cx;
    scale.cy = blend.cy;
  end

endmodule

// File: sv/fire_palette_pixel_render_unit.sv
// ----------------------------------------------------------------------------
// fire_palette_pixel_render_unit
// Turns one heat cell of a 16x48 flame into a scaled RGB pixel and its
// position on a 48x16 canvas.
// ----------------------------------------------------------------------------
// Five-stage pipeline: palette and row flare, flare products, whitening and
// clamp, brightness multiply, divide by 255 into the output register. One
// pixel enters per clock while heat_stall is low; each stage loads
// whenever it is empty or the stage after it moves, so bubbles close up
// behind a stalled output. Configuration writes are always taken
// (cfg_ready is high) and apply to pixels accepted afterward.
module fire_palette_pixel_render_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       heat_valid,
  output logic       heat_stall,
  input  logic [7:0] heat_value,
  input  logic [3:0] column,
  input  logic [5:0] row,
  output logic       pixel_valid,
  input  logic       pixel_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [5:0] canvas_x,
  output logic [3:0] canvas_y
);
  import fpr_pkg::*;

  logic [7:0] brightness;
  logic [7:0] flare_level;
  logic       stack_reverse;
  logic       row_invert;

  logic [5:1] v;
  logic [6:1] adv;

  front_t front_c, s1;
  flare_t flare_c, s2;
  blend_t blend_c, s3;
  scale_t scale_c, s4;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= BrightnessReset;
      flare_level   <= '0;
      stack_reverse <= 1'b0;
      row_invert    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BRIGHTNESS:    brightness    <= cfg_data;
        REG_FLARE_LEVEL:   flare_level   <= cfg_data;
        REG_STACK_REVERSE: stack_reverse <= cfg_data[0];
        REG_ROW_INVERT:    row_invert    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a stage loads when empty or when its contents move on
  always_comb begin
    adv[6] = !pixel_stall;
    for (int k = 5; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign heat_stall = !adv[1];

  fpr_front u_front (
    .heat_value    (heat_value),
    .column        (column),
    .row           (row),
    .brightness    (brightness),
    .flare_level   (flare_level),
    .stack_reverse (stack_reverse),
    .row_invert    (row_invert),
    .front         (front_c)
  );

  fpr_flare u_flare (.front(s1), .flare(flare_c));
  fpr_blend u_blend (.flare(s2), .blend(blend_c));
  fpr_scale u_scale (.blend(s3), .scale(scale_c));

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) v[1] <= heat_valid;
      if (adv[2]) v[2] <= v[1];
      if (adv[3]) v[3] <= v[2];
      if (adv[4]) v[4] <= v[3];
      if (adv[5]) v[5] <= v[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) s1 <= front_c;
    if (adv[2]) s2 <= flare_c;
    if (adv[3]) s3 <= blend_c;
    if (adv[4]) s4 <= scale_c;
    if (adv[5]) begin
      red      <= div255(s4.pr);
      green    <= div255(s4.pg);
      blue     <= div255(s4.pb);
      canvas_x <= s4.cx;
      canvas_y <= s4.cy;
    end
  end

  assign pixel_valid = v[5];

  // an accepted pixel always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    heat_valid && !heat_stall |=> v[1])
    else $error("accepted pixel did not enter stage 1");

  // an empty first stage never back-pressures the input
  a_open_when_empty: assert property (@(posedge clk) disable iff (rst)
    !v[1] |-> !heat_stall)
    else $error("input stalled with empty stage 1");

  // the capped brightness bounds every scaled channel
  a_channel_cap: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> (red <= BrightnessCap) && (green <= BrightnessCap)
                    && (blue <= BrightnessCap))
    else $error("channel exceeds brightness cap");

  // a taken pixel with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    v[5] && !pixel_stall && !v[4] |=> !pixel_valid)
    else $error("pixel repeated at output");

endmodule
